// File: rtl/gbfw_pkg.sv
// Shared types and codes for the graph breadth first walk block.
package gbfw_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int MAX_EDGES_DEF = 256;

    localparam logic [1:0] K_ADD   = 2'd0;
    localparam logic [1:0] K_WALK  = 2'd1;
    localparam logic [1:0] K_CLEAR = 2'd2;

    localparam logic [1:0] ST_VISITED = 2'd0;
    localparam logic [1:0] ST_ADDED   = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;
    localparam logic [1:0] ST_CLEARED = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] from_node;
        logic [5:0] to_node;
        logic       one_way;
        logic [5:0] start_node;
        logic       keep_visited;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] visited_node;
        logic       last;
    } t_out;

endpackage

// File: rtl/graph_breadth_first_walk.sv
// Top level: graph builder and breadth first walker over per-node neighbor lists.
//
// Input channel: an item is taken at a rising edge where start is high and busy
// is low. Add-edge items append to neighbor lists, clear items empty the graph,
// walk items visit the nodes reachable from start_node in breadth first order,
// skipping other nodes marked by earlier walks if keep_visited is set. Result
// channel: each result shows on o_result for one cycle with o_strobe high; the
// final result of an item has last set. Results cannot be held off.
// Per item: a dropped edge or a clear is answered straight from idle, a one-way
// edge passes through S_ADD_A, a two-way edge through S_ADD_A and S_ADD_B (one
// read-modify-write of the node memory per stored entry). In a walk each node
// costs a queue read and a node memory read, each neighbor one edge memory
// read, all chained through synchronous reads. A walk from a start_node at or
// above MAX_NODES is answered straight from idle; kind 3 gives no result.
// Reset empties the graph and the visited map at once through per-node valid
// bits; no clearing pass is needed, the block is ready right after reset.
module graph_breadth_first_walk import gbfw_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_EDGES = MAX_EDGES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_item,
    output logic busy,
    output logic o_strobe,
    output t_out o_result
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int IW = $clog2(MAX_EDGES);
    localparam int UW = $clog2(MAX_EDGES + 1);
    localparam logic [6:0]    NODE_LIM  = 7'(MAX_NODES);
    localparam logic [UW:0]   EDGE_LIM  = (UW + 1)'(MAX_EDGES);
    localparam logic [CW-1:0] QUEUE_LIM = CW'(MAX_NODES);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ADD_A = 6'b000010,
        S_ADD_B = 6'b000100,
        S_DEQ   = 6'b001000,
        S_NODE  = 6'b010000,
        S_EDGE  = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    t_in                   r_item, n_item;
    logic [MAX_NODES-1:0]  r_nvalid, n_nvalid;
    logic [UW-1:0]         r_edges_used, n_edges_used;
    logic [MAX_NODES-1:0]  r_visited, n_visited;
    logic [CW-1:0]         r_q_rd, n_q_rd;
    logic [CW-1:0]         r_q_wr, n_q_wr;
    logic [NW-1:0]         r_cur, n_cur;
    logic [IW-1:0]         r_e, n_e;
    logic [IW-1:0]         r_tail, n_tail;
    logic                  r_strobe, n_strobe;
    t_out                  r_result, n_result;

    logic [2*IW-1:0]       node_mem [MAX_NODES];
    logic [2*IW-1:0]       r_node_q;
    logic                  r_node_fwd_hit;
    logic [2*IW-1:0]       r_node_fwd_word;
    logic [NW-1:0]         node_rd_addr;
    logic                  node_wr_en;
    logic [NW-1:0]         node_wr_addr;
    logic [2*IW-1:0]       node_wr_word;
    logic [2*IW-1:0]       node_word;
    logic [IW-1:0]         node_head;
    logic [IW-1:0]         node_tail;

    logic [NW-1:0]         queue_mem [MAX_NODES];
    logic [NW-1:0]         r_queue_q;
    logic                  r_q_fwd_hit;
    logic [NW-1:0]         r_q_fwd_data;
    logic [NW-1:0]         q_rd_addr;
    logic                  q_wr_en;
    logic [NW-1:0]         q_wr_addr;
    logic [NW-1:0]         q_wr_data;
    logic [NW-1:0]         queue_word;

    logic                  tgt_we;
    logic [IW-1:0]         tgt_addr;
    logic [NW-1:0]         tgt_data;
    logic                  link_we;
    logic [IW-1:0]         link_addr;
    logic [IW-1:0]         link_data;
    logic [IW-1:0]         edge_rd_addr;
    logic [NW-1:0]         edge_target;
    logic [IW-1:0]         edge_link;

    logic                  accept;
    logic                  from_ok;
    logic                  to_ok;
    logic                  start_ok;
    logic                  edge_fits;
    logic [NW-1:0]         app_src;
    logic [NW-1:0]         app_dst;
    logic                  app_valid;
    logic [IW-1:0]         app_e;
    logic                  enq;
    logic [CW-1:0]         q_wr_next;
    logic                  scan_done;
    logic [MAX_NODES-1:0]  walk_base;

    gbfw_edge_store #(
        .MAX_NODES(MAX_NODES),
        .MAX_EDGES(MAX_EDGES)
    ) u_edge_store (
        .i_clk      (i_clk),
        .i_tgt_we   (tgt_we),
        .i_tgt_addr (tgt_addr),
        .i_tgt_data (tgt_data),
        .i_link_we  (link_we),
        .i_link_addr(link_addr),
        .i_link_data(link_data),
        .i_rd_addr  (edge_rd_addr),
        .o_target   (edge_target),
        .o_link     (edge_link)
    );

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    assign from_ok   = {1'b0, i_item.from_node} < NODE_LIM;
    assign to_ok     = {1'b0, i_item.to_node} < NODE_LIM;
    assign start_ok  = {1'b0, i_item.start_node} < NODE_LIM;
    assign edge_fits = ({1'b0, r_edges_used} + (i_item.one_way ? (UW + 1)'(1) : (UW + 1)'(2)))
                       <= EDGE_LIM;
    assign walk_base = i_item.keep_visited ? r_visited : '0;

    assign node_word  = r_node_fwd_hit ? r_node_fwd_word : r_node_q;
    assign node_head  = node_word[2*IW-1:IW];
    assign node_tail  = node_word[IW-1:0];
    assign queue_word = r_q_fwd_hit ? r_q_fwd_data : r_queue_q;

    assign app_src   = (r_state == S_ADD_A) ? r_item.from_node[NW-1:0] : r_item.to_node[NW-1:0];
    assign app_dst   = (r_state == S_ADD_A) ? r_item.to_node[NW-1:0] : r_item.from_node[NW-1:0];
    assign app_valid = r_nvalid[app_src];
    assign app_e     = r_edges_used[IW-1:0];

    assign enq       = (r_state == S_EDGE) && !r_visited[edge_target] && (r_q_wr < QUEUE_LIM);
    assign q_wr_next = enq ? (r_q_wr + CW'(1)) : r_q_wr;
    assign scan_done = (r_state == S_NODE) ? !r_nvalid[r_cur] : (r_e == r_tail);

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_nvalid     = r_nvalid;
        n_edges_used = r_edges_used;
        n_visited    = r_visited;
        n_q_rd       = r_q_rd;
        n_q_wr       = r_q_wr;
        n_cur        = r_cur;
        n_e          = r_e;
        n_tail       = r_tail;
        n_strobe     = 1'b0;
        n_result     = r_result;
        node_rd_addr = r_cur;
        node_wr_en   = 1'b0;
        node_wr_addr = app_src;
        node_wr_word = app_valid ? {node_head, app_e} : {app_e, app_e};
        q_rd_addr    = r_q_rd[NW-1:0];
        q_wr_en      = 1'b0;
        q_wr_addr    = r_q_wr[NW-1:0];
        q_wr_data    = edge_target;
        tgt_we       = 1'b0;
        tgt_addr     = app_e;
        tgt_data     = app_dst;
        link_we      = 1'b0;
        link_addr    = node_tail;
        link_data    = app_e;
        edge_rd_addr = r_e;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_item = i_item;
                    case (i_item.kind)
                        K_ADD: begin
                            if (from_ok && to_ok && edge_fits) begin
                                node_rd_addr = i_item.from_node[NW-1:0];
                                n_state      = S_ADD_A;
                            end else begin
                                n_strobe = 1'b1;
                                n_result = '{status: ST_DROPPED, visited_node: 6'd0, last: 1'b1};
                            end
                        end
                        K_CLEAR: begin
                            n_nvalid     = '0;
                            n_edges_used = '0;
                            n_strobe     = 1'b1;
                            n_result     = '{status: ST_CLEARED, visited_node: 6'd0, last: 1'b1};
                        end
                        K_WALK: begin
                            n_visited = walk_base;
                            if (start_ok) begin
                                n_visited[i_item.start_node[NW-1:0]] = 1'b1;
                                n_cur        = i_item.start_node[NW-1:0];
                                node_rd_addr = i_item.start_node[NW-1:0];
                                n_q_rd       = '0;
                                n_q_wr       = '0;
                                n_state      = S_NODE;
                            end else begin
                                n_strobe = 1'b1;
                                n_result = '{status: ST_VISITED,
                                             visited_node: i_item.start_node, last: 1'b1};
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD_A, S_ADD_B: begin
                tgt_we                = 1'b1;
                link_we               = app_valid;
                node_wr_en            = 1'b1;
                n_nvalid[app_src]     = 1'b1;
                n_edges_used          = r_edges_used + UW'(1);
                if ((r_state == S_ADD_A) && !r_item.one_way) begin
                    node_rd_addr = r_item.to_node[NW-1:0];
                    n_state      = S_ADD_B;
                end else begin
                    n_strobe = 1'b1;
                    n_result = '{status: ST_ADDED, visited_node: 6'd0, last: 1'b1};
                    n_state  = S_IDLE;
                end
            end
            S_DEQ: begin
                n_cur        = queue_word;
                node_rd_addr = queue_word;
                n_state      = S_NODE;
            end
            S_NODE, S_EDGE: begin
                if (enq) begin
                    n_visited[edge_target] = 1'b1;
                    q_wr_en                = 1'b1;
                    n_q_wr                 = q_wr_next;
                end
                if (scan_done) begin
                    n_strobe = 1'b1;
                    n_result = '{status: ST_VISITED, visited_node: 6'(r_cur),
                                 last: (r_q_rd == q_wr_next)};
                    if (r_q_rd == q_wr_next) begin
                        n_state = S_IDLE;
                    end else begin
                        n_q_rd  = r_q_rd + CW'(1);
                        n_state = S_DEQ;
                    end
                end else if (r_state == S_NODE) begin
                    edge_rd_addr = node_head;
                    n_e          = node_head;
                    n_tail       = node_tail;
                    n_state      = S_EDGE;
                end else begin
                    edge_rd_addr = edge_link;
                    n_e          = edge_link;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_nvalid       <= '0;
            r_edges_used   <= '0;
            r_visited      <= '0;
            r_q_rd         <= '0;
            r_q_wr         <= '0;
            r_strobe       <= 1'b0;
            r_node_fwd_hit <= 1'b0;
            r_q_fwd_hit    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_nvalid       <= n_nvalid;
            r_edges_used   <= n_edges_used;
            r_visited      <= n_visited;
            r_q_rd         <= n_q_rd;
            r_q_wr         <= n_q_wr;
            r_strobe       <= n_strobe;
            r_node_fwd_hit <= node_wr_en && (node_wr_addr == node_rd_addr);
            r_q_fwd_hit    <= q_wr_en && (q_wr_addr == q_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_item          <= n_item;
        r_cur           <= n_cur;
        r_e             <= n_e;
        r_tail          <= n_tail;
        r_result        <= n_result;
        r_node_fwd_word <= node_wr_word;
        r_q_fwd_data    <= q_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (node_wr_en) begin
            node_mem[node_wr_addr] <= node_wr_word;
        end
        r_node_q <= node_mem[node_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (q_wr_en) begin
            queue_mem[q_wr_addr] <= q_wr_data;
        end
        r_queue_q <= queue_mem[q_rd_addr];
    end

endmodule

// File: rtl/gbfw_edge_store.sv
// Edge store: target and link memories of the shared neighbor lists.
module gbfw_edge_store import gbfw_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_EDGES = MAX_EDGES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_tgt_we,
    input  logic [$clog2(MAX_EDGES)-1:0] i_tgt_addr,
    input  logic [$clog2(MAX_NODES)-1:0] i_tgt_data,
    input  logic                         i_link_we,
    input  logic [$clog2(MAX_EDGES)-1:0] i_link_addr,
    input  logic [$clog2(MAX_EDGES)-1:0] i_link_data,
    input  logic [$clog2(MAX_EDGES)-1:0] i_rd_addr,
    output logic [$clog2(MAX_NODES)-1:0] o_target,
    output logic [$clog2(MAX_EDGES)-1:0] o_link
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int IW = $clog2(MAX_EDGES);

    logic [NW-1:0] target_mem [MAX_EDGES];
    logic [IW-1:0] link_mem   [MAX_EDGES];

    always_ff @(posedge i_clk) begin
        if (i_tgt_we) begin
            target_mem[i_tgt_addr] <= i_tgt_data;
        end
        o_target <= target_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_link_we) begin
            link_mem[i_link_addr] <= i_link_data;
        end
        o_link <= link_mem[i_rd_addr];
    end

endmodule

// File: rtl/gbfw_checker.sv
// Port-level checker for the graph breadth first walk block, with its bind.
module gbfw_checker import gbfw_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input t_in  i_item,
    input logic busy,
    input logic o_strobe,
    input t_out o_result
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_strobe)
        else $error("block not idle after reset");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last |-> !busy)
        else $error("busy while final result shown");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |-> busy)
        else $error("intermediate result while idle");

    a_clear_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.kind == K_CLEAR)
        |=> o_strobe && (o_result.status == ST_CLEARED) && o_result.last)
        else $error("clear transaction not answered next cycle");

    a_edge_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.status != ST_VISITED)
        |-> o_result.last && (o_result.visited_node == 6'd0))
        else $error("bad fields on non-walk result");

endmodule

bind graph_breadth_first_walk gbfw_checker u_gbfw_checker (.*);

// File: test/tb.sv
// Testbench for graph_breadth_first_walk: transactions checked against a local graph model.
module tb import gbfw_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF    = 6;
    localparam int          NODES       = MAX_NODES_DEF;
    localparam int          EDGES       = MAX_EDGES_DEF;
    localparam logic [8:0]  NIL         = 9'(EDGES);
    localparam int          IN_W        = $bits(t_in);
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          TAIL_CYCLES = 450;
    localparam int          MAX_REPORTS = 40;
    localparam logic [1:0]  K_UNUSED    = 2'd3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_in  i_item  = '0;
    logic busy;
    logic o_strobe;
    t_out o_result;

    logic [8:0]  nbr_head [NODES];
    logic [8:0]  nbr_tail [NODES];
    logic [5:0]  edge_dst [EDGES];
    logic [8:0]  edge_next [EDGES];
    int unsigned edge_count;
    logic [63:0] visited_bits;
    t_out        pending_answers [$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          no_gaps     = 1'b0;

    graph_breadth_first_walk uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_answers.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic void empty_graph();
        for (int i = 0; i < NODES; i++) begin
            nbr_head[i] = NIL;
            nbr_tail[i] = NIL;
        end
        edge_count = 0;
    endfunction

    function automatic void store_edge(input logic [5:0] src, input logic [5:0] dst);
        logic [8:0] e;
        e = 9'(edge_count);
        edge_dst[e]  = dst;
        edge_next[e] = NIL;
        if (nbr_head[src] == NIL)
            nbr_head[src] = e;
        else
            edge_next[nbr_tail[src]] = e;
        nbr_tail[src] = e;
        edge_count++;
    endfunction

    function automatic void push_answer(input logic [1:0] status, input logic [5:0] node,
                                        input logic last);
        t_out r;
        r.status       = status;
        r.visited_node = node;
        r.last         = last;
        pending_answers.insert(pending_answers.size(), r);
    endfunction

    function automatic void compute_answers(input t_in it);
        logic [5:0]  order [NODES];
        int          rd;
        int          wr;
        int unsigned need;
        logic [8:0]  e;
        logic [5:0]  cur;
        case (it.kind)
            K_ADD: begin
                need = it.one_way ? 1 : 2;
                if (edge_count + need > EDGES) begin
                    push_answer(ST_DROPPED, 6'd0, 1'b1);
                end else begin
                    store_edge(it.from_node, it.to_node);
                    if (!it.one_way)
                        store_edge(it.to_node, it.from_node);
                    push_answer(ST_ADDED, 6'd0, 1'b1);
                end
            end
            K_CLEAR: begin
                empty_graph();
                push_answer(ST_CLEARED, 6'd0, 1'b1);
            end
            K_WALK: begin
                if (!it.keep_visited)
                    visited_bits = '0;
                visited_bits[it.start_node] = 1'b1;
                order[0] = it.start_node;
                rd = 0;
                wr = 1;
                while (rd < wr) begin
                    cur = order[rd];
                    rd++;
                    e = nbr_head[cur];
                    while (e != NIL) begin
                        if (!visited_bits[edge_dst[e]] && wr < NODES) begin
                            visited_bits[edge_dst[e]] = 1'b1;
                            order[wr] = edge_dst[e];
                            wr++;
                        end
                        e = edge_next[e];
                    end
                    push_answer(ST_VISITED, cur, rd == wr);
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_strobe) begin
            if (pending_answers.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d node=%0d last=%0b",
                                          o_result.status, o_result.visited_node,
                                          o_result.last));
            end else begin
                want = pending_answers.pop_front();
                if (o_result.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_result.status, want.status));
                if (o_result.visited_node !== want.visited_node)
                    report_mismatch($sformatf("visited_node %0d, want %0d",
                                              o_result.visited_node, want.visited_node));
                if (o_result.last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b (status %0d node %0d)",
                                              o_result.last, want.last,
                                              want.status, want.visited_node));
            end
        end
    end

    function automatic t_in random_item(input logic [1:0] kind);
        t_in it;
        it = t_in'(IN_W'($urandom()));
        it.kind = kind;
        return it;
    endfunction

    function automatic t_in edge_item(input int src, input int dst, input bit one_way);
        t_in it;
        it = random_item(K_ADD);
        it.from_node = 6'(src);
        it.to_node   = 6'(dst);
        it.one_way   = one_way;
        return it;
    endfunction

    function automatic t_in walk_item(input int from, input bit keep);
        t_in it;
        it = random_item(K_WALK);
        it.start_node   = 6'(from);
        it.keep_visited = keep;
        return it;
    endfunction

    task automatic pause_sender();
        int roll;
        int gap;
        if (no_gaps)
            return;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            gap = 0;
        else if (roll < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_item(input t_in it);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        compute_answers(it);
        pause_sender();
    endtask

    task automatic wait_for_answers();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_answers.size() != 0);
    endtask

    task automatic test_directed();
        send_item(random_item(K_CLEAR));
        send_item(random_item(K_UNUSED));
        send_item(edge_item(0, 1, 1'b0));
        send_item(edge_item(1, 2, 1'b0));
        send_item(edge_item(2, 63, 1'b1));
        send_item(edge_item(0, 3, 1'b0));
        send_item(edge_item(5, 5, 1'b0));
        send_item(edge_item(63, 0, 1'b1));
        send_item(edge_item(3, 4, 1'b1));
        send_item(walk_item(0, 1'b0));
        send_item(walk_item(0, 1'b1));
        send_item(walk_item(5, 1'b0));
        send_item(walk_item(63, 1'b1));
        send_item(walk_item(63, 1'b0));
        wait_for_answers();
        send_item(walk_item(40, 1'b0));
        send_item(random_item(K_CLEAR));
        send_item(walk_item(0, 1'b1));
        send_item(walk_item(0, 1'b0));
        send_item(edge_item(63, 63, 1'b1));
        send_item(walk_item(63, 1'b1));
        send_item(random_item(K_UNUSED));
        send_item(random_item(K_CLEAR));
    endtask

    task automatic test_store_full();
        send_item(random_item(K_CLEAR));
        for (int i = 0; i < EDGES / 2 - 1; i++)
            send_item(edge_item($urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1),
                                1'b0));
        send_item(edge_item($urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1), 1'b1));
        send_item(edge_item($urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1), 1'b0));
        send_item(edge_item($urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1), 1'b1));
        send_item(edge_item($urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1), 1'b1));
        send_item(edge_item($urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1), 1'b0));
        send_item(walk_item($urandom_range(0, NODES - 1), 1'b0));
        send_item(walk_item($urandom_range(0, NODES - 1), 1'b1));
        wait_for_answers();
        send_item(random_item(K_CLEAR));
    endtask

    task automatic test_random_graphs(input int unsigned items);
        int unsigned sent;
        int          span;
        int          base;
        int          edges;
        int          walks;
        int          roll;
        sent = 0;
        while (sent < items) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            span = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 12)
                                              : $urandom_range(13, NODES);
            base = $urandom_range(0, NODES - span);
            if ($urandom_range(0, 4) != 0) begin
                send_item(random_item(K_CLEAR));
                sent++;
            end
            edges = $urandom_range(1, span + 4);
            repeat (edges) begin
                roll = $urandom_range(0, 19);
                if (roll == 0) begin
                    send_item(random_item(K_UNUSED));
                end else begin
                    if (roll == 1)
                        send_item(random_item(2'($urandom_range(0, 2))));
                    else
                        send_item(edge_item(base + $urandom_range(0, span - 1),
                                            base + $urandom_range(0, span - 1),
                                            $urandom_range(0, 2) == 0));
                    sent++;
                end
            end
            walks = $urandom_range(1, 3);
            repeat (walks) begin
                send_item(walk_item(base + $urandom_range(0, span - 1),
                                    $urandom_range(0, 1)));
                sent++;
            end
            if ($urandom_range(0, 7) == 0)
                wait_for_answers();
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        empty_graph();
        visited_bits = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_store_full();
        test_random_graphs(350);
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
